FILE: rtl/core/hkis_pkg.sv
// Shared types, field widths and function codes for the Hamming top-k search core.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package hkis_pkg;

    // Default geometry
    localparam int IMAGE_WORDS = 128;
    localparam int TABLE_DEPTH = 32;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int WIDX_W  = 7;
    localparam int DATA_W  = 32;
    localparam int SCORE_W = 13;
    localparam int FILE_W  = 16;
    localparam int IMAGE_W = 32;
    localparam int RC_W    = 6;
    localparam int RANK_W  = 5;
    localparam int POP_W   = 6;

    // Depth of the op queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [RC_W-1:0]    RC_RESET  = 6'd32;

    // Function codes of an input word
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CAND  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd2;

    // One hit; field order makes the packed value the sort key
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [FILE_W-1:0]  file;
        logic [IMAGE_W-1:0] image;
    } t_hit;

    // One op from front to back: a finished candidate or a drain
    typedef struct packed {
        logic drain;
        t_hit hit;
    } t_op;

endpackage

FILE: rtl/core/hkis_front.sv
// Front end: query word store, popcount of candidate XOR query, running distance.
// Emits finished candidates and drain commands as ops; depends on hkis_pkg.
`timescale 1ns / 1ps

module hkis_front #(
    parameter int IMAGE_WORDS = hkis_pkg::IMAGE_WORDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hkis_pkg::FUNC_W-1:0]  i_func,
    input  logic [hkis_pkg::WIDX_W-1:0]  i_word_index,
    input  logic [hkis_pkg::DATA_W-1:0]  i_data_word,
    input  logic                         i_last_word,
    input  logic [hkis_pkg::FILE_W-1:0]  i_file_index,
    input  logic [hkis_pkg::IMAGE_W-1:0] i_image_index,
    output logic                         o_push,
    output hkis_pkg::t_op                o_op,
    input  logic                         i_full
);

    localparam int AW = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;
    localparam int XW = (AW + 1 > hkis_pkg::WIDX_W) ? AW + 1 : hkis_pkg::WIDX_W;

    logic [hkis_pkg::DATA_W-1:0] r_qmem [IMAGE_WORDS];

    logic [XW-1:0] idx_x;
    logic [AW-1:0] addr;
    logic          in_range;
    logic          accept;
    logic          s1_push;
    logic          s1_go;

    logic                          r_s1_valid;
    logic                          n_s1_valid;
    logic                          r_s1_drain;
    logic                          r_s1_add;
    logic                          r_s1_last;
    logic [hkis_pkg::DATA_W-1:0]   r_s1_data;
    logic [hkis_pkg::DATA_W-1:0]   r_s1_q;
    logic [hkis_pkg::FILE_W-1:0]   r_s1_file;
    logic [hkis_pkg::IMAGE_W-1:0]  r_s1_image;
    logic [hkis_pkg::SCORE_W-1:0]  r_acc;
    logic [hkis_pkg::SCORE_W-1:0]  n_acc;

    logic [hkis_pkg::POP_W-1:0]    pop;
    logic [hkis_pkg::SCORE_W:0]    sum;
    logic [hkis_pkg::SCORE_W-1:0]  sat;

    // Decode the word address
    assign idx_x    = XW'(i_word_index);
    assign addr     = idx_x[AW-1:0];
    assign in_range = idx_x < XW'(IMAGE_WORDS);

    // Hold the input while a finished op waits on a full queue
    assign s1_push = r_s1_valid && (r_s1_drain || r_s1_last);
    assign o_stall = s1_push && i_full;
    assign s1_go   = r_s1_valid && !o_stall;
    assign accept  = i_valid && !o_stall;

    // Query store: write on load, registered read for candidates
    always_ff @(posedge i_clk) begin
        if (accept && (i_func == hkis_pkg::FUNC_LOAD) && in_range) begin
            r_qmem[addr] <= i_data_word;
        end
        if (accept) begin
            r_s1_q <= r_qmem[addr];
        end
    end

    // Capture candidate and drain words into stage one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_drain <= (i_func == hkis_pkg::FUNC_DRAIN);
            r_s1_add   <= in_range;
            r_s1_last  <= i_last_word;
            r_s1_data  <= i_data_word;
            r_s1_file  <= i_file_index;
            r_s1_image <= i_image_index;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept && ((i_func == hkis_pkg::FUNC_CAND) || (i_func == hkis_pkg::FUNC_DRAIN))) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
    end

    // Add the popcount and saturate
    always_comb begin
        pop = hkis_pkg::POP_W'($countones(r_s1_data ^ r_s1_q));
        sum = {1'b0, r_acc} + (r_s1_add ? (hkis_pkg::SCORE_W + 1)'(pop) : '0);
        sat = (sum > {1'b0, hkis_pkg::SCORE_MAX}) ? hkis_pkg::SCORE_MAX
                                                  : sum[hkis_pkg::SCORE_W-1:0];
    end

    // Advance the accumulator, clear it when a candidate completes
    always_comb begin
        n_acc = r_acc;
        if (s1_go && !r_s1_drain) begin
            n_acc = r_s1_last ? '0 : sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_acc      <= n_acc;
        end
    end

    assign o_push         = s1_go && (r_s1_drain || r_s1_last);
    assign o_op.drain     = r_s1_drain;
    assign o_op.hit.score = sat;
    assign o_op.hit.file  = r_s1_file;
    assign o_op.hit.image = r_s1_image;

endmodule

FILE: rtl/core/hkis_queue.sv
// Short op queue between the front end and the hit table.
// Register-based ring buffer of hkis_pkg::t_op; depends on hkis_pkg.
`timescale 1ns / 1ps

module hkis_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hkis_pkg::t_op i_push_op,
    output logic          o_full,
    output logic          o_head_valid,
    output hkis_pkg::t_op o_head_op,
    input  logic          i_pop
);

    localparam int QW = $clog2(hkis_pkg::QUEUE_DEPTH);

    hkis_pkg::t_op r_q [hkis_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wp;
    logic [QW-1:0] r_rp;
    logic [QW:0]   r_cnt;
    logic [QW:0]   n_cnt;

    assign o_full       = (r_cnt == (QW + 1)'(hkis_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head_op    = r_q[r_rp];

    // Store pushed ops
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_push_op;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/hkis_back.sv
// Back end: sorted hit table with parallel compare insert, drain sequencer
// and registered result word; depends on hkis_pkg.
`timescale 1ns / 1ps

module hkis_back #(
    parameter int TABLE_DEPTH = hkis_pkg::TABLE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [hkis_pkg::RC_W-1:0]    i_result_count,
    input  logic                         i_head_valid,
    input  hkis_pkg::t_op                i_head_op,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hkis_pkg::RANK_W-1:0]  o_rank,
    output logic [hkis_pkg::SCORE_W-1:0] o_score,
    output logic [hkis_pkg::FILE_W-1:0]  o_hit_file,
    output logic [hkis_pkg::IMAGE_W-1:0] o_hit_image,
    output logic                         o_valid_res,
    output logic                         o_last_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    hkis_pkg::t_hit r_tab [TABLE_DEPTH];
    hkis_pkg::t_hit ins   [TABLE_DEPTH];
    hkis_pkg::t_hit shf   [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] live;
    logic [TABLE_DEPTH-1:0] lt;
    logic [TABLE_DEPTH-1:0] eq;

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [CW-1:0]                r_left;
    logic [CW-1:0]                n_left;
    logic [hkis_pkg::RANK_W-1:0]  r_rank;
    logic [hkis_pkg::RANK_W-1:0]  n_rank;
    logic [hkis_pkg::SCORE_W-1:0] r_worst;
    logic [hkis_pkg::SCORE_W-1:0] n_worst;
    logic                         r_o_valid;
    logic                         n_o_valid;

    logic [hkis_pkg::RC_W:0]      rc_x;
    logic [CW-1:0]                lim;
    logic [CW-1:0]                c_base;
    logic [CW-1:0]                c_inc;
    logic [TW-1:0]                wsel;
    logic                         full_rej;
    logic                         take;
    logic                         do_ins;
    logic                         out_free;
    logic                         tab_ins;
    logic                         tab_shift;
    logic                         ld_empty;
    logic                         ld_hit;
    logic                         ld_last;

    // Clamp the configured limit to 1..TABLE_DEPTH
    always_comb begin
        rc_x = {1'b0, i_result_count};
        if (i_result_count == '0) begin
            lim = CW'(1);
        end else if (rc_x > (hkis_pkg::RC_W + 1)'(TABLE_DEPTH)) begin
            lim = CW'(TABLE_DEPTH);
        end else begin
            lim = CW'(rc_x);
        end
    end

    // Per-entry compare, insert shift and drain shift
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign live[g] = (CW'(g) < r_count);
        assign lt[g]   = live[g] && (r_tab[g] < i_head_op.hit);
        assign eq[g]   = live[g] && (r_tab[g] == i_head_op.hit);
        if (g == 0) begin : g_first
            assign ins[g] = lt[g] ? r_tab[g] : i_head_op.hit;
        end else begin : g_rest
            assign ins[g] = lt[g] ? r_tab[g] : (lt[g-1] ? i_head_op.hit : r_tab[g-1]);
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign shf[g] = r_tab[g];
        end else begin : g_body
            assign shf[g] = r_tab[g+1];
        end
    end

    // Decide whether a finished candidate enters the table
    always_comb begin
        full_rej = (r_count == CW'(TABLE_DEPTH)) && lt[TABLE_DEPTH-1];
        take     = (r_count < lim) || (i_head_op.hit.score < r_worst);
        do_ins   = take && !(|eq) && !full_rej;
        c_base   = (r_count == CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH - 1) : r_count;
        c_inc    = c_base + CW'(1);
        wsel     = TW'(lim - CW'(1));
    end

    assign out_free = !r_o_valid || !i_stall;

    // Sequencer: insert, start a drain, emit one hit per cycle while the output is not stalled
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_rank    = r_rank;
        n_worst   = r_worst;
        n_o_valid = r_o_valid && i_stall;
        o_pop     = 1'b0;
        tab_ins   = 1'b0;
        tab_shift = 1'b0;
        ld_empty  = 1'b0;
        ld_hit    = 1'b0;
        ld_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    if (!i_head_op.drain) begin
                        o_pop = 1'b1;
                        if (do_ins) begin
                            tab_ins = 1'b1;
                            if (c_inc > lim) begin
                                n_count = lim;
                                n_worst = ins[wsel].score;
                            end else begin
                                n_count = c_inc;
                            end
                        end
                    end else if (r_count == '0) begin
                        if (out_free) begin
                            o_pop     = 1'b1;
                            ld_empty  = 1'b1;
                            n_o_valid = 1'b1;
                            n_worst   = hkis_pkg::SCORE_MAX;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_left  = r_count;
                        n_count = '0;
                        n_rank  = '0;
                        n_worst = hkis_pkg::SCORE_MAX;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    ld_hit    = 1'b1;
                    ld_last   = (r_left == CW'(1));
                    tab_shift = 1'b1;
                    n_o_valid = 1'b1;
                    n_left    = r_left - CW'(1);
                    n_rank    = r_rank + 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table storage
    always_ff @(posedge i_clk) begin
        if (tab_ins) begin
            r_tab <= ins;
        end else if (tab_shift) begin
            r_tab <= shf;
        end
    end

    // Result word payload
    always_ff @(posedge i_clk) begin
        if (ld_empty) begin
            o_rank        <= '0;
            o_score       <= '0;
            o_hit_file    <= '0;
            o_hit_image   <= '0;
            o_valid_res   <= 1'b0;
            o_last_result <= 1'b1;
        end else if (ld_hit) begin
            o_rank        <= r_rank;
            o_score       <= r_tab[0].score;
            o_hit_file    <= r_tab[0].file;
            o_hit_image   <= r_tab[0].image;
            o_valid_res   <= 1'b1;
            o_last_result <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_rank    <= '0;
            r_worst   <= hkis_pkg::SCORE_MAX;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_rank    <= n_rank;
            r_worst   <= n_worst;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_valid = r_o_valid;

endmodule

FILE: rtl/core/hamming_top_k_image_search_core.sv
// Throughput: one input word per cycle while o_stall is low; a drain holds the table for a
// start step, then one result word per cycle while i_stall is low; an empty drain, one word.
// Path: a candidate's last word passes stage one and the op queue, then updates the table;
// a drain word takes the same path, then a start step unless the table is empty.
// Reset: synchronous, active low; clears control, hit count and worst score.
// Query store and hit table are not cleared.
`timescale 1ns / 1ps

module hamming_top_k_image_search_core #(
    parameter int IMAGE_WORDS = hkis_pkg::IMAGE_WORDS,
    parameter int TABLE_DEPTH = hkis_pkg::TABLE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hkis_pkg::FUNC_W-1:0]  i_func,
    input  logic [hkis_pkg::WIDX_W-1:0]  i_word_index,
    input  logic [hkis_pkg::DATA_W-1:0]  i_data_word,
    input  logic                         i_last_word,
    input  logic [hkis_pkg::FILE_W-1:0]  i_file_index,
    input  logic [hkis_pkg::IMAGE_W-1:0] i_image_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hkis_pkg::RANK_W-1:0]  o_rank,
    output logic [hkis_pkg::SCORE_W-1:0] o_score,
    output logic [hkis_pkg::FILE_W-1:0]  o_hit_file,
    output logic [hkis_pkg::IMAGE_W-1:0] o_hit_image,
    output logic                         o_valid_res,
    output logic                         o_last_result,
    input  logic                         i_cfg_we,
    input  logic [hkis_pkg::RC_W-1:0]    i_cfg_data
);

    logic [hkis_pkg::RC_W-1:0] r_result_count;

    logic          q_push;
    hkis_pkg::t_op q_push_op;
    logic          q_full;
    logic          q_head_valid;
    hkis_pkg::t_op q_head_op;
    logic          q_pop;

    // Result count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_count <= hkis_pkg::RC_RESET;
        end else if (i_cfg_we) begin
            r_result_count <= i_cfg_data;
        end
    end

    hkis_front #(
        .IMAGE_WORDS (IMAGE_WORDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_word_index  (i_word_index),
        .i_data_word   (i_data_word),
        .i_last_word   (i_last_word),
        .i_file_index  (i_file_index),
        .i_image_index (i_image_index),
        .o_push        (q_push),
        .o_op          (q_push_op),
        .i_full        (q_full)
    );

    hkis_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_op    (q_push_op),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head_op    (q_head_op),
        .i_pop        (q_pop)
    );

    hkis_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_result_count (r_result_count),
        .i_head_valid   (q_head_valid),
        .i_head_op      (q_head_op),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rank         (o_rank),
        .o_score        (o_score),
        .o_hit_file     (o_hit_file),
        .o_hit_image    (o_hit_image),
        .o_valid_res    (o_valid_res),
        .o_last_result  (o_last_result)
    );

`ifndef NO_ASSERTIONS
    // Input is held back only by a full op queue
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_full)
        else $error("input stalled while op queue has room");

    // Drain words follow back to back with rising rank
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_result) |=>
            (o_valid && (o_rank == $past(o_rank) + 5'd1)))
        else $error("drain sequence broken");

    // An empty-table result closes its drain and carries zeros
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |->
            (o_last_result && (o_rank == '0) && (o_score == '0)))
        else $error("malformed empty result");
`endif

endmodule

FILE: sim/hkis_tb_pkg.sv
// Scoreboard for the Hamming top-k search core: it keeps its own query store and
// sorted hit table and checks every drained hit word. Depends on hkis_pkg.
`timescale 1ns / 1ps

package hkis_tb_pkg;

    import hkis_pkg::*;

    // Unused function code: the core must ignore it
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // Field order makes the packed value the ranking key
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [FILE_W-1:0]  file;
        logic [IMAGE_W-1:0] image;
    } t_hit_key;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        t_hit_key          hit;
        logic              valid_res;
        logic              last_result;
    } t_hit_word;

    class knn_scoreboard;
        logic [DATA_W-1:0]  query_words [IMAGE_WORDS];
        logic [SCORE_W-1:0] run_dist;
        logic [SCORE_W-1:0] worst;
        logic [RC_W-1:0]    limit_reg;
        t_hit_key           ranked [$];
        t_hit_word          expected_hits [$];
        int unsigned        failures;

        function new();
            foreach (query_words[i]) query_words[i] = '0;
            run_dist  = '0;
            worst     = SCORE_MAX;
            limit_reg = RC_RESET;
            failures  = 0;
        endfunction

        function void set_limit(logic [RC_W-1:0] value);
            limit_reg = value;
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        // Zero keeps one hit, anything past the table depth keeps a full table
        function int keep_now();
            if (limit_reg == 0) return 1;
            if (int'(limit_reg) > TABLE_DEPTH) return TABLE_DEPTH;
            return int'(limit_reg);
        endfunction

        // Offer a finished candidate to the sorted table
        function void offer_hit(t_hit_key cand);
            int lim;
            int pos;
            lim = keep_now();
            pos = 0;
            if (!(ranked.size() < lim || cand.score < worst)) return;
            while (pos < ranked.size() && ranked[pos] < cand) pos++;
            if (pos < ranked.size() && ranked[pos] == cand) return;
            // a physically full table loses its last entry to the newcomer
            if (ranked.size() >= TABLE_DEPTH) begin
                if (pos >= TABLE_DEPTH) return;
                void'(ranked.pop_back());
            end
            ranked.insert(pos, cand);
            // worst score moves only when something is dropped
            if (ranked.size() > lim) begin
                while (ranked.size() > lim) void'(ranked.pop_back());
                worst = ranked[ranked.size() - 1].score;
            end
        endfunction

        // Note one accepted input word and queue the hit words it causes
        function void note_word(logic [FUNC_W-1:0] func, logic [WIDX_W-1:0] widx,
                                logic [DATA_W-1:0] data, logic last,
                                logic [FILE_W-1:0] file, logic [IMAGE_W-1:0] image);
            int        sum;
            t_hit_key  cand;
            t_hit_word w;
            case (func)
                FUNC_LOAD: begin
                    if (int'(widx) < IMAGE_WORDS) query_words[widx] = data;
                end
                FUNC_CAND: begin
                    if (int'(widx) < IMAGE_WORDS) begin
                        sum = int'(run_dist) + $countones(data ^ query_words[widx]);
                        run_dist = (sum > int'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum);
                    end
                    if (last) begin
                        cand.score = run_dist;
                        cand.file  = file;
                        cand.image = image;
                        offer_hit(cand);
                        run_dist = '0;
                    end
                end
                FUNC_DRAIN: begin
                    if (ranked.size() == 0) begin
                        w = '0;
                        w.last_result = 1'b1;
                        expected_hits.push_back(w);
                    end else begin
                        foreach (ranked[i]) begin
                            w.rank        = RANK_W'(i);
                            w.hit         = ranked[i];
                            w.valid_res   = 1'b1;
                            w.last_result = (i == ranked.size() - 1);
                            expected_hits.push_back(w);
                        end
                    end
                    ranked.delete();
                    worst = SCORE_MAX;
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one accepted hit word with the oldest expectation
        function void check_hit(t_hit_word got);
            t_hit_word want;
            bit        bad;
            if (expected_hits.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display({"unexpected hit word: rank %0d score %0d file %0d image %0d",
                              " valid %0b last %0b"},
                             got.rank, got.hit.score, got.hit.file, got.hit.image,
                             got.valid_res, got.last_result);
                return;
            end
            want = expected_hits.pop_front();
            bad = (got.rank !== want.rank) || (got.hit.score !== want.hit.score) ||
                  (got.hit.file !== want.hit.file) || (got.hit.image !== want.hit.image) ||
                  (got.valid_res !== want.valid_res) || (got.last_result !== want.last_result);
            if (bad) begin
                failures++;
                if (failures <= 10) begin
                    $display("hit word mismatch at %0t", $time);
                    $display("  expected: rank %0d score %0d file %0d image %0d valid %0b last %0b",
                             want.rank, want.hit.score, want.hit.file, want.hit.image,
                             want.valid_res, want.last_result);
                    $display("  actual:   rank %0d score %0d file %0d image %0d valid %0b last %0b",
                             got.rank, got.hit.score, got.hit.file, got.hit.image,
                             got.valid_res, got.last_result);
                end
            end
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
// Top-level bench for hamming_top_k_image_search_core: directed and random query,
// candidate and drain words with random idling and back-pressure on both sides.
// Depends on hkis_pkg and hkis_tb_pkg.
`timescale 1ns / 1ps

module tb_top;

    import hkis_pkg::*;
    import hkis_tb_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEM_TARGET   = 430;
    localparam int FAR_WORDS     = 260;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic [FUNC_W-1:0]    i_func        = FUNC_LOAD;
    logic [WIDX_W-1:0]    i_word_index  = '0;
    logic [DATA_W-1:0]    i_data_word   = '0;
    logic                 i_last_word   = 1'b0;
    logic [FILE_W-1:0]    i_file_index  = '0;
    logic [IMAGE_W-1:0]   i_image_index = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [RANK_W-1:0]    o_rank;
    logic [SCORE_W-1:0]   o_score;
    logic [FILE_W-1:0]    o_hit_file;
    logic [IMAGE_W-1:0]   o_hit_image;
    logic                 o_valid_res;
    logic                 o_last_result;
    logic                 i_cfg_we      = 1'b0;
    logic [RC_W-1:0]      i_cfg_data    = RC_RESET;

    logic                 calm          = 1'b0;
    logic                 hold_request  = 1'b0;
    logic                 hold_taken    = 1'b0;
    int                   hold_left     = 0;
    int unsigned          cycle_count   = 0;
    int                   sent_words    = 0;
    bit                   query_loaded [IMAGE_WORDS];
    int                   loaded_list [$];
    knn_scoreboard        sb = new();

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    hamming_top_k_image_search_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_word_index  (i_word_index),
        .i_data_word   (i_data_word),
        .i_last_word   (i_last_word),
        .i_file_index  (i_file_index),
        .i_image_index (i_image_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rank        (o_rank),
        .o_score       (o_score),
        .o_hit_file    (o_hit_file),
        .o_hit_image   (o_hit_image),
        .o_valid_res   (o_valid_res),
        .o_last_result (o_last_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    // Watchdog: give up at a generous cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request, none while calm
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 36);
        end
    end

    // Check every hit word taken at this edge
    always @(posedge i_clk) begin
        t_hit_word got;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got.rank        = o_rank;
            got.hit.score   = o_score;
            got.hit.file    = o_hit_file;
            got.hit.image   = o_hit_image;
            got.valid_res   = o_valid_res;
            got.last_result = o_last_result;
            sb.check_hit(got);
        end
    end

    // Offer one word, idling first at random; return at the accepting edge
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [WIDX_W-1:0] widx,
                             input logic [DATA_W-1:0] data, input logic last,
                             input logic [FILE_W-1:0] file, input logic [IMAGE_W-1:0] image);
        int gap;
        gap = 0;
        if (!calm)
            while (gap < 8 && $urandom_range(99) < 36) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_word_index  <= widx;
        i_data_word   <= data;
        i_last_word   <= last;
        i_file_index  <= file;
        i_image_index <= image;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(func, widx, data, last, file, image);
        sent_words++;
    endtask

    task automatic load_query_word(input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] data);
        send_word(FUNC_LOAD, widx, data, 1'($urandom_range(1)),
                  FILE_W'($urandom), IMAGE_W'($urandom));
        if (!query_loaded[widx]) begin
            query_loaded[widx] = 1'b1;
            loaded_list.push_back(int'(widx));
        end
    endtask

    task automatic drain_table();
        send_word(FUNC_DRAIN, WIDX_W'($urandom), DATA_W'($urandom), 1'($urandom_range(1)),
                  FILE_W'($urandom), IMAGE_W'($urandom));
    endtask

    task automatic send_noise();
        send_word(FUNC_NONE, WIDX_W'($urandom), DATA_W'($urandom), 1'($urandom_range(1)),
                  FILE_W'($urandom), IMAGE_W'($urandom));
    endtask

    // Only query words already written are ever read
    function automatic logic [WIDX_W-1:0] pick_index();
        return WIDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
    endfunction

    // Small files and images most of the time so ties and duplicates show up
    function automatic logic [FILE_W-1:0] pick_file();
        if ($urandom_range(9) < 7) return FILE_W'($urandom_range(3));
        return FILE_W'($urandom);
    endfunction

    function automatic logic [IMAGE_W-1:0] pick_image();
        if ($urandom_range(9) < 7) return IMAGE_W'($urandom_range(3));
        return IMAGE_W'($urandom);
    endfunction

    // Candidate data close to the query most of the time, for low, tied scores
    function automatic logic [DATA_W-1:0] near_word(logic [WIDX_W-1:0] widx);
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] flips;
        int                mode;
        q     = sb.query_words[widx];
        flips = '0;
        mode  = $urandom_range(9);
        if (mode < 6) begin
            repeat ($urandom_range(3)) flips[$urandom_range(DATA_W - 1)] = 1'b1;
            return q ^ flips;
        end
        if (mode < 8) return DATA_W'($urandom);
        if (mode == 8) return ~q;
        return q;
    endfunction

    // Stream one candidate; leave it open when finish is low, fully off when far is high
    task automatic send_candidate(input int n_words, input logic [FILE_W-1:0] file,
                                  input logic [IMAGE_W-1:0] image, input bit finish,
                                  input bit far);
        logic [WIDX_W-1:0] widx;
        logic [DATA_W-1:0] data;
        bit                tail;
        for (int k = 0; k < n_words; k++) begin
            widx = pick_index();
            data = far ? ~sb.query_words[widx] : near_word(widx);
            tail = finish && (k == n_words - 1);
            if (tail)
                send_word(FUNC_CAND, widx, data, 1'b1, file, image);
            else
                send_word(FUNC_CAND, widx, data, 1'b0, FILE_W'($urandom), IMAGE_W'($urandom));
        end
    endtask

    // Write the result count; the core must be idle
    task automatic write_limit(input logic [RC_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_limit(value);
        i_cfg_we   <= 1'b0;
    endtask

    // Hold input until every expected hit word is back and the table has settled
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed candidates, with query reloads, noise, drains and open candidates
    task automatic run_phase(input int span, input bit allow_drain);
        int done;
        int roll;
        int n;
        done = 0;
        while (done < span) begin
            roll = $urandom_range(99);
            if (roll < 72) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                send_candidate(n, pick_file(), pick_image(), 1'b1, 1'b0);
                done += n;
            end else if (roll < 82) begin
                load_query_word(WIDX_W'($urandom), DATA_W'($urandom));
                done++;
            end else if (roll < 88) begin
                send_noise();
                done++;
            end else if (roll < 93 && allow_drain) begin
                drain_table();
                done++;
            end else begin
                n = $urandom_range(1, 3);
                send_candidate(n, pick_file(), pick_image(), 1'b0, 1'b0);
                done += n;
            end
        end
    endtask

    function automatic logic [RC_W-1:0] phase_limit(int phase);
        case (phase)
            0:       return 6'd63;
            1:       return 6'd33;
            2:       return 6'd1;
            3:       return 6'd32;
            4:       return 6'd0;
            default: begin
                if ($urandom_range(1) == 0) return RC_W'($urandom_range(1, 6));
                return RC_W'($urandom_range(63));
            end
        endcase
    endfunction

    initial begin
        int phase;

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_limit(RC_RESET);

        // Directed: extreme query words, ignored code, empty drain
        load_query_word(7'd0, 32'h0000_0000);
        load_query_word(7'd127, 32'hFFFF_FFFF);
        load_query_word(7'd85, 32'hAAAA_AAAA);
        load_query_word(7'd42, 32'h5555_5555);
        send_word(FUNC_NONE, 7'h7F, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        drain_table();
        // exact match, then the same hit again
        send_word(FUNC_CAND, 7'd0, 32'h0000_0000, 1'b1, 16'h0000, 32'h0000_0000);
        send_word(FUNC_CAND, 7'd0, 32'h0000_0000, 1'b1, 16'h0000, 32'h0000_0000);
        // two fully different words, top file and image
        send_word(FUNC_CAND, 7'd127, 32'h0000_0000, 1'b0, 16'h1234, 32'h0000_0000);
        send_word(FUNC_CAND, 7'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        // equal scores ordered by file, then image
        send_word(FUNC_CAND, 7'd85, 32'h5555_5555, 1'b1, 16'h0001, 32'h0000_0002);
        send_word(FUNC_CAND, 7'd42, 32'hAAAA_AAAA, 1'b1, 16'h0001, 32'h0000_0001);
        send_word(FUNC_CAND, 7'd42, 32'hAAAA_AAAA, 1'b1, 16'h0000, 32'h0000_0009);
        // distance carries across words until the last one
        send_word(FUNC_CAND, 7'd85, 32'hAAAA_FFFF, 1'b0, 16'h0000, 32'h0000_0000);
        send_word(FUNC_CAND, 7'd42, 32'h5555_5555, 1'b1, 16'h0002, 32'h0000_0003);
        drain_table();
        settle();

        // Directed: a zero limit keeps one hit; the worst score lags the first drop
        write_limit(6'd0);
        send_word(FUNC_CAND, 7'd0, 32'h0000_0001, 1'b1, 16'h0005, 32'h0000_0005);
        send_word(FUNC_CAND, 7'd0, 32'h0000_0003, 1'b1, 16'h0005, 32'h0000_0006);
        send_word(FUNC_CAND, 7'd0, 32'h0000_0000, 1'b1, 16'h0005, 32'h0000_0007);
        drain_table();

        // Random phases, each under its own limit
        phase = 0;
        while (sent_words < ITEM_TARGET) begin
            settle();
            write_limit(phase_limit(phase));
            calm <= (phase == 3);
            if (phase == 1) begin
                // send eleven candidates, then drain into a held-off receiver
                send_candidate(2, pick_file(), pick_image(), 1'b1, 1'b0);
                repeat (10) send_candidate(1, pick_file(), pick_image(), 1'b1, 1'b0);
                hold_request <= 1'b1;
                drain_table();
            end
            if (phase == 5) begin
                // enough full mismatches to saturate the distance
                send_candidate(FAR_WORDS, FILE_W'($urandom), IMAGE_W'($urandom), 1'b1, 1'b1);
            end
            if (phase == 0)
                run_phase(20, 1'b0);
            else if (phase == 3)
                run_phase(30, 1'b1);
            else
                run_phase($urandom_range(15, 25), 1'b1);
            if (phase == 1 || $urandom_range(99) < 85) drain_table();
            phase++;
        end
        drain_table();

        // Wait out the last hit words and the pipeline tail
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
